// File: hw/rtl/lodd_pkg.sv
// shared types and constants of the lock order deadlock detector
`default_nettype none
package lodd_pkg;

   localparam int LOCK_COUNT_DEF   = 64;
   localparam int THREAD_COUNT_DEF = 4;
   localparam int STACK_DEPTH_DEF  = 16;

   localparam int OP_W     = 1;
   localparam int TID_W    = 2;
   localparam int LID_W    = 6;
   localparam int STATUS_W = 3;
   localparam int DEPTH_W  = 5;

   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DEADLOCK     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MULTI_UNLOCK = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_UNLOCK   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL         = 3'd4;

   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;        // capture input beat
      logic read_top;    // read stack top of thread
      logic check_top;   // evaluate top against lock, read order row
      logic srch_start;  // seed the walk
      logic srch_pop;    // take one found lock and issue its row read
      logic srch_expand; // merge the returned row
      logic commit;      // apply result and build response
   } lodd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_search; // acquire needing a reachability walk
      logic srch_empty;  // no found lock left to expand
      logic srch_hit;    // taken lock equals target
   } lodd_stat_type;

endpackage
`default_nettype wire

// File: hw/rtl/lodd_datapath.sv
// datapath: order matrix, lock stacks, pointers and reachability walk state
`default_nettype none
module lodd_datapath
   import lodd_pkg::*;
#(
   parameter int LOCK_COUNT   = LOCK_COUNT_DEF,
   parameter int THREAD_COUNT = THREAD_COUNT_DEF,
   parameter int STACK_DEPTH  = STACK_DEPTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lodd_cmd_type        cmd,
   output lodd_stat_type            stat,
   input  wire logic [OP_W-1:0]     in_operation,
   input  wire logic [TID_W-1:0]    in_thread_id,
   input  wire logic [LID_W-1:0]    in_lock_id,
   output logic [STATUS_W-1:0]      out_status,
   output logic [DEPTH_W-1:0]       out_stack_depth
);
   localparam int LW  = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
   localparam int TW  = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
   localparam int PW  = $clog2(STACK_DEPTH + 1);
   localparam int HD  = THREAD_COUNT * STACK_DEPTH;
   localparam int HW  = $clog2(HD) > 0 ? $clog2(HD) : 1;
   localparam logic [LW:0] LOCK_MOD   = (LW+1)'(LOCK_COUNT);
   localparam logic [TW:0] THREAD_MOD = (TW+1)'(THREAD_COUNT);

   // order matrix: row valid bits stand for the all-zero reset
   logic [LOCK_COUNT-1:0] matrix_mem [LOCK_COUNT];
   logic [LOCK_COUNT-1:0] row_valid_ff;
   logic [LOCK_COUNT-1:0] row_rd_ff;
   logic [LOCK_COUNT-1:0] top_row_ff;  // row of the top lock, kept across the walk
   logic [LW-1:0]         held_mem [HD];
   logic [LW-1:0]         top_rd_ff;

   logic [PW-1:0]  sp_ff [THREAD_COUNT];
   logic [OP_W-1:0] op_ff;
   logic [TW-1:0]  tid_ff;
   logic [LW-1:0]  lock_ff;
   logic [PW-1:0]  sp_cur_ff;
   logic           blocked_ff, need_ff, edge_add_ff;
   logic [LOCK_COUNT-1:0] visited_ff;
   logic [LOCK_COUNT-1:0] pend_ff;  // locks found but not yet expanded
   logic           hit_ff;

   logic [TW-1:0] tid_mod;
   logic [LW-1:0] lock_mod;
   logic [PW-1:0] sp_sel;
   logic [HW-1:0] top_addr, push_addr;
   logic [LOCK_COUNT-1:0] new_bits, low_bit;
   logic [LW-1:0] low_idx;

   // remainder by the lock count, one compare and subtract per input bit
   function automatic logic [LW-1:0] lock_rem(input logic [LID_W-1:0] v);
      logic [LW:0] r;
      r = '0;
      for (int i = LID_W - 1; i >= 0; i--) begin
         r = {r[LW-1:0], v[i]};
         if (r >= LOCK_MOD) r = r - LOCK_MOD;
      end
      return r[LW-1:0];
   endfunction

   function automatic logic [TW-1:0] thread_rem(input logic [TID_W-1:0] v);
      logic [TW:0] r;
      r = '0;
      for (int i = TID_W - 1; i >= 0; i--) begin
         r = {r[TW-1:0], v[i]};
         if (r >= THREAD_MOD) r = r - THREAD_MOD;
      end
      return r[TW-1:0];
   endfunction

   always_comb begin
      tid_mod  = thread_rem(in_thread_id);
      lock_mod = lock_rem(in_lock_id);
   end

   assign sp_sel    = (sp_ff[tid_ff] > PW'(STACK_DEPTH)) ? PW'(STACK_DEPTH) : sp_ff[tid_ff];
   assign top_addr  = HW'(32'(tid_ff) * STACK_DEPTH + 32'(sp_sel) - 1);
   assign push_addr = HW'(32'(tid_ff) * STACK_DEPTH + 32'(sp_cur_ff));

   // lowest pending bit
   always_comb begin
      low_bit = pend_ff & (~pend_ff + LOCK_COUNT'(1));
      low_idx = '0;
      for (int i = 0; i < LOCK_COUNT; i++)
         if (low_bit[i]) low_idx = LW'(i);
   end
   assign new_bits = row_rd_ff & ~visited_ff;

   // matrix port
   always_ff @(posedge clock) begin
      if (cmd.commit && edge_add_ff && !blocked_ff)
         matrix_mem[top_rd_ff] <= top_row_ff | (LOCK_COUNT'(1) << lock_ff);
      if (cmd.check_top)
         top_row_ff <= row_valid_ff[top_rd_ff] ? matrix_mem[top_rd_ff] : '0;
      else if (cmd.srch_pop)
         row_rd_ff <= row_valid_ff[low_idx] ? matrix_mem[low_idx] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) row_valid_ff <= '0;
      else if (cmd.commit && edge_add_ff && !blocked_ff)
         row_valid_ff[top_rd_ff] <= 1'b1;
   end

   // held stacks
   always_ff @(posedge clock) begin
      if (cmd.commit && !blocked_ff && op_ff == OP_ACQUIRE && sp_cur_ff < PW'(STACK_DEPTH))
         held_mem[push_addr] <= lock_ff;
      if (cmd.read_top)
         top_rd_ff <= held_mem[top_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < THREAD_COUNT; t++) sp_ff[t] <= '0;
         pend_ff <= '0;
         hit_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            op_ff   <= in_operation;
            tid_ff  <= tid_mod;
            lock_ff <= lock_mod;
         end
         if (cmd.read_top) begin
            sp_cur_ff <= sp_sel;
            blocked_ff <= 1'b0;
            edge_add_ff <= 1'b0;
            need_ff <= 1'b0;
            hit_ff <= 1'b0;
         end
         if (cmd.check_top) begin
            // top register valid only when sp nonzero
            need_ff <= op_ff == OP_ACQUIRE && sp_cur_ff != '0 && top_rd_ff != lock_ff;
         end
         if (cmd.srch_start) begin
            visited_ff  <= LOCK_COUNT'(1) << lock_ff;
            pend_ff     <= LOCK_COUNT'(1) << lock_ff;
            // edge goes in unless the walk finds the top lock
            edge_add_ff <= 1'b1;
         end else if (cmd.srch_pop) begin
            pend_ff <= pend_ff & ~low_bit;
            if (low_idx == top_rd_ff) hit_ff <= 1'b1;
         end else if (cmd.srch_expand) begin
            visited_ff <= visited_ff | new_bits;
            pend_ff    <= pend_ff | new_bits;
            if (hit_ff) blocked_ff <= 1'b1;
         end
         if (cmd.commit) begin
            if (op_ff == OP_ACQUIRE) begin
               if (!blocked_ff && sp_cur_ff < PW'(STACK_DEPTH))
                  sp_ff[tid_ff] <= sp_cur_ff + PW'(1);
               else
                  sp_ff[tid_ff] <= sp_cur_ff;
            end else if (sp_cur_ff != '0 && top_rd_ff == lock_ff) begin
               sp_ff[tid_ff] <= sp_cur_ff - PW'(1);
            end
         end
      end
   end

   // need_search: new distinct lock and edge not in row of top
   always_comb begin
      stat.need_search = need_ff && !top_row_ff[lock_ff];
      stat.srch_empty  = (pend_ff == '0);
      stat.srch_hit    = hit_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (op_ff == OP_ACQUIRE) begin
            if (blocked_ff) begin
               out_status <= ST_DEADLOCK;
               out_stack_depth <= DEPTH_W'(sp_cur_ff);
            end else if (sp_cur_ff >= PW'(STACK_DEPTH)) begin
               out_status <= ST_FULL;
               out_stack_depth <= DEPTH_W'(sp_cur_ff);
            end else begin
               out_status <= ST_OK;
               out_stack_depth <= DEPTH_W'(sp_cur_ff + PW'(1));
            end
         end else if (sp_cur_ff == '0) begin
            out_status <= ST_MULTI_UNLOCK;
            out_stack_depth <= '0;
         end else if (top_rd_ff != lock_ff) begin
            out_status <= ST_BAD_UNLOCK;
            out_stack_depth <= DEPTH_W'(sp_cur_ff);
         end else begin
            out_status <= ST_OK;
            out_stack_depth <= DEPTH_W'(sp_cur_ff - PW'(1));
         end
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/lodd_control.sv
// controller state machine sequencing one event at a time
`default_nettype none
module lodd_control
   import lodd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output lodd_cmd_type       cmd,
   input  wire lodd_stat_type stat
);
   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_TOP    = 8'b0000_0010,
      S_CHECK  = 8'b0000_0100,
      S_DECIDE = 8'b0000_1000,
      S_POP    = 8'b0001_0000,
      S_WAIT   = 8'b0010_0000,
      S_EXPAND = 8'b0100_0000,
      S_COMMIT = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_vld_ff, rsp_vld_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      rsp_vld_in = rsp_vld_ff && !rsp_tready;
      req_tready = (state_ff == S_IDLE) && !rsp_vld_ff;
      case (state_ff)
         S_IDLE: if (req_tvalid && req_tready) begin
            cmd.load = 1'b1;
            state_in = S_TOP;
         end
         S_TOP: begin
            cmd.read_top = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check_top = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (stat.need_search) begin
               cmd.srch_start = 1'b1;
               state_in = S_POP;
            end else state_in = S_COMMIT;
         end
         S_POP: begin
            if (stat.srch_hit) state_in = S_EXPAND;
            else if (stat.srch_empty) state_in = S_COMMIT;
            else begin
               cmd.srch_pop = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: state_in = S_EXPAND;
         S_EXPAND: begin
            cmd.srch_expand = 1'b1;
            state_in = stat.srch_hit ? S_COMMIT : S_POP;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            rsp_vld_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
endmodule
`default_nettype wire

// File: hw/rtl/lock_order_deadlock_detector_top.sv
// top level of the lock order deadlock detector
//
// req channel: one beat per lock event; tuser carries the operation (acquire
// or release), tdata the thread and the lock.
// rsp channel: exactly one beat per event with status and the thread's depth.
// events are handled one at a time. a release, an acquire on an empty stack,
// a re-acquire of the top lock or an already known edge passes through the
// top read, check and decide states to commit, which raises rsp_tvalid.
// an acquire adding a new edge runs a reachability walk over the order matrix:
// each visited lock costs a pop, a row read and a merge, and the walk ends
// when no found lock is left or the top lock is found; the single matrix
// row read port lets the walk read only one row at a time.
// the next event is taken the cycle after the result beat, so a new event
// is never taken before the result beat of the last one has gone.
// reset clears all stack pointers and marks every matrix row empty through
// per-row valid bits, so no clearing pass is needed.
// the result sits in an output register until taken; while it waits the
// block takes no new event.
`default_nettype none
module lock_order_deadlock_detector_top
   import lodd_pkg::*;
#(
   parameter int LOCK_COUNT   = LOCK_COUNT_DEF,
   parameter int THREAD_COUNT = THREAD_COUNT_DEF,
   parameter int STACK_DEPTH  = STACK_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // thread_id[1:0], lock_id[7:2]
   input  wire logic [0:0]  req_tuser,  // operation[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata   // status[2:0], stack_depth[7:3]
);
   lodd_cmd_type  cmd;
   lodd_stat_type stat;
   logic [STATUS_W-1:0] st;
   logic [DEPTH_W-1:0]  dp;

   lodd_control u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .cmd, .stat
   );

   lodd_datapath #(
      .LOCK_COUNT(LOCK_COUNT), .THREAD_COUNT(THREAD_COUNT), .STACK_DEPTH(STACK_DEPTH)
   ) u_dp (
      .clock, .reset, .cmd, .stat,
      .in_operation(req_tuser),
      .in_thread_id(req_tdata[1:0]),
      .in_lock_id(req_tdata[7:2]),
      .out_status(st),
      .out_stack_depth(dp)
   );

   assign rsp_tdata = {dp, st};
endmodule
`default_nettype wire
